### hw/rtl/fpra_pkg.sv
// Package for the fit policy range allocator.
// Holds request/result payload types, status and policy codes, and the
// controller/datapath command and status structs. No dependencies.
package fpra_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ID    = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_ZERO_ARG = 2'd3;

  localparam logic [1:0] KIND_FIRST = 2'd0;
  localparam logic [1:0] KIND_SMALL = 2'd1;
  localparam logic [1:0] KIND_LARGE = 2'd2;
  localparam logic [2:0] POLICY_MAX = 3'd5;

  localparam logic [1:0] CFG_REGION_BEGIN = 2'd0;
  localparam logic [1:0] CFG_REGION_END   = 2'd1;
  localparam logic [1:0] CFG_RECORD_SIZE  = 2'd2;
  localparam logic [1:0] CFG_PAGE_NUMBER  = 2'd3;

  localparam logic [15:0] RST_REGION_BEGIN = 16'd256;
  localparam logic [16:0] RST_REGION_END   = 17'd4096;
  localparam logic [7:0]  RST_RECORD_SIZE  = 8'd32;

  typedef struct packed {
    logic [2:0]  policy;
    logic [31:0] elem_bytes;
    logic [31:0] elem_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame_number;
    logic [15:0] block_offset;
    logic [16:0] free_bytes;
    logic [31:0] header_page;
    logic [31:0] header_elem_size;
    logic [31:0] header_elem_capacity;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_APPLY, S_SORT_INIT, S_SORT,
    S_MERGE_INIT, S_MERGE, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
    logic sort_init;
    logic sort_step;
    logic merge_init;
    logic merge_step;
    logic merge_close;
  } cmd_t;

  typedef struct packed {
    logic pre_fail;
    logic scan_done;
    logic merge_pol;
    logic sort_last;
    logic any_valid;
    logic merge_end;
  } stat_t;

endpackage

### hw/rtl/fpra_ctrl.sv
// Controller for the fit policy range allocator.
// Sequences check, scan, apply, sort and coalesce; depends on fpra_pkg.
module fpra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  fpra_pkg::stat_t stat,
  output fpra_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import fpra_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK:      state_next = stat.pre_fail ? S_DONE : S_SCAN;
      S_SCAN: begin
        if (stat.scan_done) state_next = S_APPLY;
        else                cmd.scan_step = 1'b1;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = stat.merge_pol ? S_SORT_INIT : S_DONE;
      end
      S_SORT_INIT: begin
        cmd.sort_init = 1'b1;
        state_next    = S_SORT;
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (stat.sort_last) state_next = S_MERGE_INIT;
      end
      S_MERGE_INIT: begin
        cmd.merge_init = 1'b1;
        state_next     = stat.any_valid ? S_MERGE : S_DONE;
      end
      S_MERGE: begin
        if (stat.merge_end) begin
          cmd.merge_close = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.merge_step = 1'b1;
        end
      end
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

### hw/rtl/fpra_dpath.sv
// Datapath for the fit policy range allocator: config registers, free range
// list, id counter, free byte count and result registers. Uses fpra_pkg.
module fpra_dpath #(
  parameter int FREE_SLOTS = 16,
  parameter int MAX_FRAMES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  fpra_pkg::req_t  request,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  fpra_pkg::cmd_t  cmd,
  output fpra_pkg::stat_t stat,
  output fpra_pkg::res_t  result
);
  import fpra_pkg::*;

  localparam int IW  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW  = $clog2(FREE_SLOTS + 1);
  localparam int IDW = $clog2(MAX_FRAMES + 1);

  logic [15:0] region_begin;
  logic [16:0] region_end;
  logic [7:0]  record_size;
  logic [31:0] page_number;

  logic [16:0]    rb [FREE_SLOTS];
  logic [16:0]    re [FREE_SLOTS];
  logic           vld [FREE_SLOTS];
  logic [CW-1:0]  range_count;
  logic [IDW-1:0] id_len;
  logic [16:0]    free_count;

  req_t        req;
  logic [1:0]  status;
  logic [3:0]  fid;
  logic [15:0] offset;

  logic [IW-1:0] si;
  logic [CW-1:0] sleft;
  logic          found;
  logic [IW-1:0] fi;
  logic [16:0]   best;

  logic [IW-1:0] phase;
  logic [CW-1:0] mi;
  logic [CW-1:0] top;
  logic [16:0]   cur_b, cur_e;

  logic [1:0]  kind;
  logic [16:0] len;
  logic        fit, take;
  logic [16:0] mb, me;
  logic [1:0]  pre_code;
  logic [15:0] nb;
  logic [16:0] ne;

  assign kind = req.policy[2:1];
  assign len  = (rb[si] < re[si]) ? (re[si] - rb[si]) : 17'd0;
  assign fit  = (record_size != 8'd0) && (len >= {9'd0, record_size});

  always_comb begin
    take = 1'b0;
    if (fit) begin
      priority if (!found)            take = 1'b1;
      else if (kind == KIND_SMALL)    take = (len < best);
      else if (kind == KIND_LARGE)    take = (len > best);
      else                            take = 1'b0;
    end
  end

  assign mb = rb[mi[IW-1:0]];
  assign me = re[mi[IW-1:0]];

  always_comb begin
    priority if (request.elem_bytes == 32'd0 || request.elem_count == 32'd0)
      pre_code = ST_ZERO_ARG;
    else if (id_len == '0)              pre_code = ST_NO_ID;
    else if (request.policy > POLICY_MAX) pre_code = ST_NO_SPACE;
    else                                pre_code = ST_OK;
  end

  assign nb = (cfg_index == CFG_REGION_BEGIN) ? cfg_data[15:0] : region_begin;
  assign ne = (cfg_index == CFG_REGION_END)   ? cfg_data[16:0] : region_end;

  assign stat.pre_fail  = (status != ST_OK);
  assign stat.scan_done = (sleft == '0) || (kind == KIND_FIRST && found);
  assign stat.merge_pol = req.policy[0];
  assign stat.sort_last = (phase == IW'(FREE_SLOTS - 1));
  assign stat.any_valid = vld[0];
  assign stat.merge_end = (mi == CW'(FREE_SLOTS)) || !vld[mi[IW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      region_begin <= RST_REGION_BEGIN;
      region_end   <= RST_REGION_END;
      record_size  <= RST_RECORD_SIZE;
      page_number  <= '0;
      for (int k = 1; k < FREE_SLOTS; k++) begin
        rb[k] <= '0;
        re[k] <= '0;
      end
      rb[0]       <= {1'b0, RST_REGION_BEGIN};
      re[0]       <= RST_REGION_END;
      range_count <= CW'(1);
      id_len      <= IDW'(MAX_FRAMES);
      free_count  <= RST_REGION_END - {1'b0, RST_REGION_BEGIN};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_BEGIN: region_begin <= cfg_data[15:0];
        CFG_REGION_END:   region_end   <= cfg_data[16:0];
        CFG_RECORD_SIZE:  record_size  <= cfg_data[7:0];
        CFG_PAGE_NUMBER:  page_number  <= cfg_data;
        default: ;
      endcase
      // region writes rebuild the stores from the new bounds
      if (cfg_index == CFG_REGION_BEGIN || cfg_index == CFG_REGION_END) begin
        for (int k = 1; k < FREE_SLOTS; k++) begin
          rb[k] <= '0;
          re[k] <= '0;
        end
        rb[0]  <= {1'b0, nb};
        re[0]  <= ne;
        id_len <= IDW'(MAX_FRAMES);
        if (ne > {1'b0, nb}) begin
          range_count <= CW'(1);
          free_count  <= ne - {1'b0, nb};
        end else begin
          range_count <= '0;
          free_count  <= '0;
        end
      end
    end else begin
      if (cmd.apply && found) begin
        rb[fi]     <= rb[fi] + {9'd0, record_size};
        free_count <= (free_count >= {9'd0, record_size}) ?
                      free_count - {9'd0, record_size} : 17'd0;
        id_len     <= id_len - IDW'(1);
      end
      if (cmd.sort_step) begin
        // odd-even transposition: empty slots sink to the top
        for (int k = 0; k < FREE_SLOTS - 1; k++) begin
          if ((k % 2) == int'(phase[0])) begin
            if ((!vld[k] && vld[k+1]) || (vld[k] && vld[k+1] && rb[k] > rb[k+1])) begin
              rb[k]    <= rb[k+1];
              re[k]    <= re[k+1];
              rb[k+1]  <= rb[k];
              re[k+1]  <= re[k];
            end
          end
        end
      end
      if (cmd.merge_init && !vld[0]) range_count <= '0;
      if (cmd.merge_step && mb > cur_e) begin
        rb[top[IW-1:0]] <= cur_b;
        re[top[IW-1:0]] <= cur_e;
      end
      if (cmd.merge_close) begin
        rb[top[IW-1:0]] <= cur_b;
        re[top[IW-1:0]] <= cur_e;
        range_count     <= top + CW'(1);
      end
    end
  end

  // valid bits travel with their entries through the sort
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      for (int k = 0; k < FREE_SLOTS; k++)
        vld[k] <= (CW'(k) < range_count) && (rb[k] < re[k]);
    end else if (cmd.sort_step) begin
      for (int k = 0; k < FREE_SLOTS - 1; k++) begin
        if ((k % 2) == int'(phase[0])) begin
          if ((!vld[k] && vld[k+1]) || (vld[k] && vld[k+1] && rb[k] > rb[k+1])) begin
            vld[k]   <= vld[k+1];
            vld[k+1] <= vld[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req    <= request;
      status <= pre_code;
      si     <= IW'(range_count - CW'(1));
      sleft  <= range_count;
      found  <= 1'b0;
      best   <= '0;
      fid    <= '0;
      offset <= '0;
    end
    if (cmd.scan_step && sleft != '0) begin
      if (take) begin
        found <= 1'b1;
        fi    <= si;
        best  <= len;
      end
      si    <= si - IW'(1);
      sleft <= sleft - CW'(1);
    end
    if (cmd.apply) begin
      if (found) begin
        offset <= rb[fi][15:0];
        fid    <= 4'(IDW'(MAX_FRAMES) - id_len);
      end else begin
        status <= ST_NO_SPACE;
      end
    end
    if (cmd.sort_init) phase <= '0;
    if (cmd.sort_step) phase <= phase + IW'(1);
    if (cmd.merge_init) begin
      cur_b <= rb[0];
      cur_e <= re[0];
      top   <= '0;
      mi    <= CW'(1);
    end
    if (cmd.merge_step) begin
      if (mb <= cur_e) begin
        if (me > cur_e) cur_e <= me;
      end else begin
        top   <= top + CW'(1);
        cur_b <= mb;
        cur_e <= me;
      end
      mi <= mi + CW'(1);
    end
  end

  always_comb begin
    result.status               = status;
    result.free_bytes           = free_count;
    result.frame_number         = '0;
    result.block_offset         = '0;
    result.header_page          = '0;
    result.header_elem_size     = '0;
    result.header_elem_capacity = '0;
    if (status == ST_OK) begin
      result.frame_number         = fid;
      result.block_offset         = offset;
      result.header_page          = page_number;
      result.header_elem_size     = req.elem_bytes;
      result.header_elem_capacity = req.elem_count;
    end
  end

endmodule

### hw/rtl/fit_policy_range_allocator_top.sv
// Top level of the fit policy range allocator.
// Joins fpra_ctrl and fpra_dpath; depends on fpra_pkg.
//
// Usage:
//   Request channel: drive request and raise start; the request is taken at a
//   clock edge where start is high and busy is low. busy stays high until the
//   result has been shown.
//   Result channel: done is high for exactly one cycle with the result on
//   result. The receiver cannot stall; the result must be taken then.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. cfg_ready
//   is low while busy. Writing region_begin or region_end rebuilds the
//   free list, the frame id pool and the free byte count.
// Sequence, accept to done: a check state, the scan over the listed ranges
//   (first fit stops after its hit), an apply state and the done state;
//   merge policies add a sort setup, the odd-even sort, a coalesce setup
//   and the coalesce walk, which is skipped when no valid range is left.
//   Early errors go from the check state straight to done.
//   One request at a time; the next may start the cycle after done.
// Reset: synchronous rst restores the register defaults and one free range
//   from 256 to 4096 with all MAX_FRAMES frame ids free.
module fit_policy_range_allocator_top #(
  parameter int FREE_SLOTS = 16,
  parameter int MAX_FRAMES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fpra_pkg::req_t  request,
  output logic            busy,
  output logic            done,
  output fpra_pkg::res_t  result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import fpra_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // hold config writes off while a request is in flight
  assign cfg_ready = !busy;

  fpra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  fpra_dpath #(
    .FREE_SLOTS (FREE_SLOTS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.frame_number == 4'd0 && result.block_offset == 16'd0))
    else $error("error result carries frame fields");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");

endmodule
